>>> rtl/core/rkd_pkg.sv
// rkd_pkg: shared types, constants and helpers for the rotary knob detent mode selector
// no dependencies; used by rkd_step, the top level and the port checker

package rkd_pkg;

  localparam int unsigned ANGLE_W  = 12;
  localparam int unsigned THRESH_W = 11;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // number of selectable modes, 2 to 16
  localparam int unsigned MODE_TOTAL = 5;

  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(16);
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(9);
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_W'(1);
  localparam logic [MODE_W-1:0]   MODE_LAST  = MODE_W'(MODE_TOTAL - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DETENT_SHIFT   = CFG_IDX_W'(1);

  typedef struct packed {
    logic                primed;
    logic [ANGLE_W-1:0]  last_moved_angle;
    logic [ANGLE_W-1:0]  anchor_angle;
    logic                step_armed;
    logic                active_turn;
    logic [MODE_W-1:0]   mode_index;
  } knob_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] current_mode;
    logic              step_pulse;
    logic              step_up;
    logic              turn_began;
    logic              commit_pulse;
    logic              turning;
  } knob_result_t;

  // wrapping mode step, mode is always below MODE_TOTAL
  function automatic logic [MODE_W-1:0] mode_step(input logic [MODE_W-1:0] mode,
                                                  input logic up);
    logic [MODE_W-1:0] res;
    if (up) begin
      res = (mode == MODE_LAST) ? '0 : mode + MODE_W'(1);
    end else begin
      res = (mode == '0) ? MODE_LAST : mode - MODE_W'(1);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rkd_step.sv
// rkd_step: next-state and result logic for one angle sample
// depends on rkd_pkg for the state and result structs

module rkd_step (
  input  rkd_pkg::knob_state_t                   state,
  input  logic [rkd_pkg::ANGLE_W-1:0]            angle,
  input  logic [rkd_pkg::THRESH_W-1:0]           move_threshold,
  input  logic [rkd_pkg::SHIFT_W-1:0]            detent_shift,
  output rkd_pkg::knob_state_t                   state_nxt,
  output rkd_pkg::knob_result_t                  result
);

  logic [rkd_pkg::ANGLE_W:0]   diff;
  logic [rkd_pkg::ANGLE_W:0]   diff_abs;
  logic [rkd_pkg::ANGLE_W-1:0] mag;
  logic                        moving;
  logic                        up;
  logic [rkd_pkg::ANGLE_W-1:0] offset;
  logic [rkd_pkg::ANGLE_W-1:0] offset_sh;
  logic                        detent_bit;

  always_comb begin
    diff       = {1'b0, angle} - {1'b0, state.last_moved_angle};
    diff_abs   = diff[rkd_pkg::ANGLE_W] ? (~diff + 1'b1) : diff;
    mag        = diff_abs[rkd_pkg::ANGLE_W-1:0];
    moving     = mag > {1'b0, move_threshold};
    // sign gives direction, half a turn or more means the angle wrapped
    up         = ~diff[rkd_pkg::ANGLE_W] ^ mag[rkd_pkg::ANGLE_W-1];
    offset     = angle - state.anchor_angle;
    offset_sh  = offset >> detent_shift;
    detent_bit = offset_sh[0];

    state_nxt = state;
    result    = '0;

    if (!state.primed) begin
      state_nxt.primed           = 1'b1;
      state_nxt.last_moved_angle = angle;
      state_nxt.anchor_angle     = angle;
    end else if (moving) begin
      result.turn_began          = ~state.active_turn;
      state_nxt.active_turn      = 1'b1;
      state_nxt.last_moved_angle = angle;
      if (detent_bit) begin
        state_nxt.step_armed = 1'b0;
      end else if (!state.step_armed) begin
        state_nxt.step_armed = 1'b1;
        state_nxt.mode_index = rkd_pkg::mode_step(state.mode_index, up);
        result.step_pulse    = 1'b1;
        result.step_up       = up;
      end
    end else begin
      if (state.active_turn) begin
        state_nxt.step_armed = 1'b1;
        result.commit_pulse  = 1'b1;
      end
      state_nxt.active_turn  = 1'b0;
      state_nxt.anchor_angle = state.last_moved_angle;
    end

    result.current_mode = state_nxt.mode_index;
    result.turning      = state_nxt.active_turn;
  end

endmodule

>>> rtl/core/rotary_knob_detent_mode_selector.sv
// rotary_knob_detent_mode_selector: top level of the knob mode selector
// depends on rkd_pkg and rkd_step

// usage
// - input channel: in_valid / in_stall carry one 12-bit absolute angle sample per
//   transfer; a transfer happens when in_valid is high and in_stall low
// - result channel: out_valid / out_stall carry exactly one result per sample
//   (mode, step pulse and direction, turn start, commit, turning flag)
// - config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 is move_threshold, index 1 is detent_shift; cfg_ready is always high;
//   write only while no sample is in flight
// - path: a transferred sample is held in the input register, then its result in
//   the result register, from which the result transfer is made
//   (one input register, one result register)
// - throughput: one sample per cycle while out_stall is low, set by the
//   combinational state update in rkd_step between the input and result registers
// - reset (rst_n low, synchronous): both channels empty, thresholds back to 16
//   and 9, knob unprimed, mode 1, turn active, step armed
// - when the receiver stalls, the result holds; the input register still takes
//   a sample if it is empty, then in_stall rises until the result is taken

module rotary_knob_detent_mode_selector (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rkd_pkg::ANGLE_W-1:0]      in_angle_sample,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rkd_pkg::MODE_W-1:0]       out_current_mode,
  output logic                             out_step_pulse,
  output logic                             out_step_up,
  output logic                             out_turn_began,
  output logic                             out_commit_pulse,
  output logic                             out_turning,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkd_pkg::THRESH_W-1:0]     cfg_data
);

  // configuration registers
  logic [rkd_pkg::THRESH_W-1:0] thresh_r;
  logic [rkd_pkg::SHIFT_W-1:0]  shift_r;

  // input stage
  logic                         in_vld_r;
  logic [rkd_pkg::ANGLE_W-1:0]  angle_r;

  // knob state and result stage
  rkd_pkg::knob_state_t  state_r;
  rkd_pkg::knob_state_t  state_nxt;
  rkd_pkg::knob_result_t res_nxt;
  rkd_pkg::knob_result_t res_r;
  logic                  out_vld_r;

  logic adv;       // result register can take a new result this cycle
  logic in_xfer;   // input transfer this cycle
  logic work;      // sample in the input register is processed this cycle

  assign adv      = ~out_vld_r | ~out_stall;
  assign in_stall = in_vld_r & ~adv;
  assign in_xfer  = in_valid & ~in_stall;
  assign work     = in_vld_r & adv;
  assign cfg_ready = 1'b1;

  rkd_step u_step (
    .state          (state_r),
    .angle          (angle_r),
    .move_threshold (thresh_r),
    .detent_shift   (shift_r),
    .state_nxt      (state_nxt),
    .result         (res_nxt)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rkd_pkg::THRESH_RST;
      shift_r  <= rkd_pkg::SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rkd_pkg::REG_MOVE_THRESHOLD: thresh_r <= cfg_data;
        rkd_pkg::REG_DETENT_SHIFT:   shift_r  <= cfg_data[rkd_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: refills whenever the held sample moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (work) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      angle_r <= in_angle_sample;
    end
  end

  // knob state advances exactly once per processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.primed           <= 1'b0;
      state_r.last_moved_angle <= '0;
      state_r.anchor_angle     <= '0;
      state_r.step_armed       <= 1'b1;
      state_r.active_turn      <= 1'b1;
      state_r.mode_index       <= rkd_pkg::MODE_RST;
    end else if (work) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_current_mode = res_r.current_mode;
  assign out_step_pulse   = res_r.step_pulse;
  assign out_step_up      = res_r.step_up;
  assign out_turn_began   = res_r.turn_began;
  assign out_commit_pulse = res_r.commit_pulse;
  assign out_turning      = res_r.turning;

endmodule

>>> rtl/core/rkd_checker.sv
// rkd_checker: port-level checks on the knob mode selector result channel
// depends on rkd_pkg; bound to rotary_knob_detent_mode_selector below

module rkd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rkd_pkg::MODE_W-1:0]   out_current_mode,
  input logic                         out_step_pulse,
  input logic                         out_step_up,
  input logic                         out_turn_began,
  input logic                         out_commit_pulse,
  input logic                         out_turning
);

  // a stalled result stays valid and holds its mode, step pulse and commit pulse
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_mode)
      && $stable(out_step_pulse) && $stable(out_commit_pulse))
    else $error("stalled result changed");

  // mode always stays in range
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_mode < rkd_pkg::MODE_W'(rkd_pkg::MODE_TOTAL))
    else $error("mode out of range");

  // direction only reported with a step, and a step only while turning
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_step_up || out_step_pulse) |-> out_step_pulse && out_turning)
    else $error("step flags inconsistent");

  // a commit ends the turn, a turn start begins one
  a_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_commit_pulse && out_turning) && !(out_turn_began && !out_turning))
    else $error("turn flags inconsistent");

  // a step never coincides with a commit
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_step_pulse && out_commit_pulse))
    else $error("step and commit together");

endmodule

bind rotary_knob_detent_mode_selector rkd_checker u_rkd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_current_mode (out_current_mode),
  .out_step_pulse   (out_step_pulse),
  .out_step_up      (out_step_up),
  .out_turn_began   (out_turn_began),
  .out_commit_pulse (out_commit_pulse),
  .out_turning      (out_turning)
);
